// ===== hw/rtl/vgrw_pkg.sv =====
// vgrw_pkg: shared types, codes and constants of the voxel grid ray walk
// depends on nothing; imported by every module of the block but the checker vgrw_chk
package vgrw_pkg;

    localparam int NumAxes  = 3;
    localparam int MaxSide  = 16;
    localparam int CellW    = 4;
    localparam int SideW    = 5;
    localparam int PosW     = 32;
    localparam int DirW     = 16;
    localparam int SizeW    = 31;
    localparam int DistW    = 32;
    localparam int NumW     = 48;
    localparam int FracDirW = 14;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    localparam logic [DistW-1:0] InfDist = '1;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_GRID_SIDE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_X     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_Y     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_Z     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_X    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_Y    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_SIZE_Z    = 3'd6;

    // division phases of the setup
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DIST  = 2'd1;
    localparam logic [1:0] PH_SPAC  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_go;
        logic [1:0] phase;
        logic       div_save;
        logic       step;
        logic       emit_out;
    } vgrw_cmd_t;

    typedef struct packed {
        logic div_done;
        logic outside;
        logic leaves;
        logic out_free;
    } vgrw_sts_t;

endpackage

// ===== hw/rtl/vgrw_ifs.sv =====
// vgrw_ifs: valid/ready channel interfaces for ray beats and voxel beats
// depends on nothing
interface vgrw_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface vgrw_vox_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic [3:0]  cell_z;
    logic [31:0] exit_distance;
    logic        outside_start;
    logic        last;

    modport source (output valid, cell_x, cell_y, cell_z, exit_distance, outside_start,
                    last, input ready);
    modport sink (input valid, cell_x, cell_y, cell_z, exit_distance, outside_start, last,
                  output ready);
endinterface

// ===== hw/rtl/vgrw_div.sv =====
// vgrw_div: one-bit-per-cycle restoring divider, 48-bit by 32-bit, saturating quotient
// depends on vgrw_pkg
module vgrw_div
    import vgrw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [NumW-1:0]    num,
    input  logic [DistW-1:0]   den,
    output logic               busy,
    output logic [DistW-1:0]   quo,
    output logic [DistW-1:0]   rem
);

    logic             busy_reg, busy_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [DistW-1:0] rem_reg, rem_next;
    logic [DistW-1:0] low_reg, low_next;
    logic [DistW-1:0] den_reg, den_next;
    logic [DistW:0]   trial;
    logic             fits;

    // one restoring step
    assign trial = {rem_reg, low_reg[DistW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            den_next  = den;
            ovf_next  = {16'b0, num[NumW-1:DistW]} >= den;
            rem_next  = {16'b0, num[NumW-1:DistW]};
            low_next  = num[DistW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DistW'(trial - {1'b0, den_reg}) : trial[DistW-1:0];
            low_next = {low_reg[DistW-2:0], fits};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = ovf_reg ? InfDist : low_reg;
    assign rem  = rem_reg;

endmodule

// ===== hw/rtl/vgrw_ctrl.sv =====
// vgrw_ctrl: sequencer of setup divisions, outside result and voxel walk
// depends on vgrw_pkg
module vgrw_ctrl
    import vgrw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       ray_valid,
    output logic       ray_ready,
    input  vgrw_sts_t  sts,
    output vgrw_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GO   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ray_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = PH_START;
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_save = 1'b1;
                    if (phase_reg == PH_START && sts.outside)
                        state_next = S_OUT;
                    else if (phase_reg == PH_SPAC)
                        state_next = S_WALK;
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = S_GO;
                    end
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.out_free)
                begin
                    cmd.step = 1'b1;
                    if (sts.leaves)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_START;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign ray_ready = (state_reg == S_IDLE);

endmodule

// ===== hw/rtl/vgrw_dp.sv =====
// vgrw_dp: configuration registers, per-axis setup lanes, walk state and output register
// depends on vgrw_pkg, vgrw_ifs, vgrw_div
module vgrw_dp
    import vgrw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    vgrw_ray_if.sink            ray,
    vgrw_vox_if.source          vox,
    input  vgrw_cmd_t           cmd,
    output vgrw_sts_t           sts
);

    // configuration
    logic [SideW-1:0]        side_cfg_reg;
    logic signed [PosW-1:0]  gmin_reg [NumAxes];
    logic [SizeW-1:0]        csize_reg [NumAxes];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= SideW'(MaxSide);
            for (int a = 0; a < NumAxes; a++)
            begin
                gmin_reg[a]  <= '0;
                csize_reg[a] <= SizeW'(65536);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_SIDE: side_cfg_reg <= cfg_data[SideW-1:0];
                CFG_MIN_X:     gmin_reg[0]  <= cfg_data;
                CFG_MIN_Y:     gmin_reg[1]  <= cfg_data;
                CFG_MIN_Z:     gmin_reg[2]  <= cfg_data;
                CFG_SIZE_X:    csize_reg[0] <= cfg_data[SizeW-1:0];
                CFG_SIZE_Y:    csize_reg[1] <= cfg_data[SizeW-1:0];
                CFG_SIZE_Z:    csize_reg[2] <= cfg_data[SizeW-1:0];
                default:       ;
            endcase
        end
    end

    // effective side, clamped to one..MaxSide
    logic [SideW-1:0] side;
    always_comb
    begin
        priority if (side_cfg_reg == '0)
            side = SideW'(1);
        else if (side_cfg_reg > SideW'(MaxSide))
            side = SideW'(MaxSide);
        else
            side = side_cfg_reg;
    end

    // ray inputs per axis
    logic signed [PosW-1:0] org_in [NumAxes];
    logic signed [DirW-1:0] dir_in [NumAxes];
    assign org_in[0] = ray.origin_x;
    assign org_in[1] = ray.origin_y;
    assign org_in[2] = ray.origin_z;
    assign dir_in[0] = ray.dir_x;
    assign dir_in[1] = ray.dir_y;
    assign dir_in[2] = ray.dir_z;

    // per-axis lanes
    logic [PosW:0]      diff_reg  [NumAxes];
    logic               neg_reg   [NumAxes];
    logic [DirW-1:0]    adir_reg  [NumAxes];
    logic [SizeW-1:0]   rem_reg   [NumAxes];
    logic [CellW-1:0]   cell_reg  [NumAxes];
    logic [DistW-1:0]   nbd_reg   [NumAxes];
    logic [DistW-1:0]   sp_reg    [NumAxes];
    logic [SizeW-1:0]   cs_eff    [NumAxes];
    logic [DistW-1:0]   quo       [NumAxes];
    logic [DistW-1:0]   rem       [NumAxes];
    logic               busy      [NumAxes];
    logic               far       [NumAxes];

    // walk selection signals, shared by the lanes
    logic [1:0]       sel;
    logic [DistW-1:0] sel_nbd;
    logic [DistW-1:0] sel_sp;
    logic [CellW-1:0] sel_cell;
    logic             sel_neg;
    logic             leaves;
    logic [DistW:0]   sum;
    logic [DistW-1:0] sat_sum;

    genvar g;
    generate
        for (g = 0; g < NumAxes; g++)
        begin : g_lane
            logic [NumW-1:0]  num;
            logic [DistW-1:0] den;
            logic [SizeW-1:0] ad;
            logic [PosW:0]    diff;

            assign cs_eff[g] = (csize_reg[g] == '0) ? SizeW'(1) : csize_reg[g];
            assign diff = {org_in[g][PosW-1], org_in[g]} - {gmin_reg[g][PosW-1], gmin_reg[g]};

            // distance from origin to first boundary along the step direction
            assign ad = neg_reg[g] ? rem_reg[g] : SizeW'(cs_eff[g] - rem_reg[g]);

            // dividend and divisor for the phase in hand
            always_comb
            begin
                unique case (cmd.phase)
                    PH_START:
                    begin
                        num = diff_reg[g][PosW] ? '0 : NumW'(diff_reg[g]);
                        den = DistW'(cs_eff[g]);
                    end
                    PH_DIST:
                    begin
                        num = NumW'({ad, {FracDirW{1'b0}}});
                        den = DistW'(adir_reg[g]);
                    end
                    PH_SPAC:
                    begin
                        num = NumW'({cs_eff[g], {FracDirW{1'b0}}});
                        den = DistW'(adir_reg[g]);
                    end
                    default:
                    begin
                        num = '0;
                        den = '0;
                    end
                endcase
            end

            vgrw_div u_div (
                .clk  (clk),
                .rst_n(rst_n),
                .go   (cmd.div_go),
                .num  (num),
                .den  (den),
                .busy (busy[g]),
                .quo  (quo[g]),
                .rem  (rem[g])
            );

            assign far[g] = diff_reg[g][PosW] || (quo[g] >= DistW'(side));

            // lane registers
            always_ff @(posedge clk)
            begin
                if (cmd.load)
                begin
                    diff_reg[g] <= diff;
                    neg_reg[g]  <= dir_in[g][DirW-1];
                    adir_reg[g] <= dir_in[g][DirW-1] ? DirW'(-dir_in[g]) : dir_in[g];
                end
                if (cmd.div_save)
                begin
                    unique case (cmd.phase)
                        PH_START:
                        begin
                            cell_reg[g] <= quo[g][CellW-1:0];
                            rem_reg[g]  <= rem[g][SizeW-1:0];
                        end
                        PH_DIST: nbd_reg[g] <= quo[g];
                        PH_SPAC: sp_reg[g]  <= quo[g];
                        default: ;
                    endcase
                end
                else if (cmd.step && !leaves && sel == g)
                begin
                    cell_reg[g] <= neg_reg[g] ? cell_reg[g] - CellW'(1) : cell_reg[g] + CellW'(1);
                    nbd_reg[g]  <= sat_sum;
                end
            end
        end
    endgenerate

    // axis with the smallest exit distance, lowest axis on a tie
    always_comb
    begin
        sel = 2'd0;
        if (nbd_reg[1] < nbd_reg[0])
            sel = 2'd1;
        if (nbd_reg[2] < nbd_reg[sel])
            sel = 2'd2;
    end

    assign sel_nbd  = nbd_reg[sel];
    assign sel_sp   = sp_reg[sel];
    assign sel_cell = cell_reg[sel];
    assign sel_neg  = neg_reg[sel];
    assign leaves   = sel_neg ? (sel_cell == '0)
                              : ({1'b0, sel_cell} + SideW'(1) >= side);
    assign sum      = {1'b0, sel_nbd} + {1'b0, sel_sp};
    assign sat_sum  = sum[DistW] ? InfDist : sum[DistW-1:0];

    // output register
    logic             ovalid_reg;
    logic [CellW-1:0] ocx_reg, ocy_reg, ocz_reg;
    logic [DistW-1:0] odist_reg;
    logic             oout_reg, olast_reg;
    logic             out_free;

    assign out_free = !ovalid_reg || vox.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.step || cmd.emit_out)
            ovalid_reg <= 1'b1;
        else if (vox.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_out)
        begin
            ocx_reg   <= '0;
            ocy_reg   <= '0;
            ocz_reg   <= '0;
            odist_reg <= '0;
            oout_reg  <= 1'b1;
            olast_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            ocx_reg   <= cell_reg[0];
            ocy_reg   <= cell_reg[1];
            ocz_reg   <= cell_reg[2];
            odist_reg <= sel_nbd;
            oout_reg  <= 1'b0;
            olast_reg <= leaves;
        end
    end

    assign vox.valid         = ovalid_reg;
    assign vox.cell_x        = ocx_reg;
    assign vox.cell_y        = ocy_reg;
    assign vox.cell_z        = ocz_reg;
    assign vox.exit_distance = odist_reg;
    assign vox.outside_start = oout_reg;
    assign vox.last          = olast_reg;

    // status to the sequencer
    assign sts.div_done = !busy[0];
    assign sts.outside  = far[0] || far[1] || far[2];
    assign sts.leaves   = leaves;
    assign sts.out_free = out_free;

endmodule

// ===== hw/rtl/voxel_grid_ray_walk_top.sv =====
// Voxel grid ray walk: takes one ray beat and returns the voxels it crosses in a cubic grid,
// one voxel beat each, with its exit distance; last marks the final voxel. Setup runs up to
// three rounds of one-bit-per-cycle division (start cell, first boundary distance, boundary
// spacing) in three axis lanes running side by side, then one voxel beat per cycle while
// the output is taken, up to 46 voxels. A ray starting outside the grid gives one flagged
// beat. The next ray is taken once the last beat is registered. Configuration is to be
// written through cfg_we/cfg_index/cfg_data while the block is idle; nothing enforces it.
// depends on vgrw_pkg, vgrw_ifs, vgrw_ctrl, vgrw_dp
module voxel_grid_ray_walk_top
    import vgrw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    vgrw_ray_if.sink            ray,
    vgrw_vox_if.source          vox
);

    vgrw_cmd_t cmd;
    vgrw_sts_t sts;

    // sequencer
    vgrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .ray_valid(ray.valid),
        .ray_ready(ray.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    vgrw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .ray      (ray),
        .vox      (vox),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== hw/rtl/vgrw_chk.sv =====
// vgrw_chk: port-level checks of the voxel grid ray walk, bound to the top level
// depends on the top level's ports only
module vgrw_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        ray_valid,
    input logic        ray_ready,
    input logic        vox_valid,
    input logic        vox_ready,
    input logic [3:0]  cell_x,
    input logic [3:0]  cell_y,
    input logic [3:0]  cell_z,
    input logic [31:0] exit_distance,
    input logic        outside_start,
    input logic        last
);

    // a voxel beat stays offered until taken
    a_vox_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && !vox_ready |=> vox_valid)
        else $error("voxel beat dropped before taken");

    // one ray at a time: no new ray the cycle after one is taken
    a_one_ray: assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid && ray_ready |=> !ray_ready)
        else $error("ray taken while another is in setup");

    // an outside beat is the lone, zeroed, final beat
    a_outside: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && outside_start |-> last && exit_distance == 32'd0
            && cell_x == 4'd0 && cell_y == 4'd0 && cell_z == 4'd0)
        else $error("outside beat not flagged final and zero");

    // no ray taken while a non-final voxel beat of a walk is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        vox_valid && !last |-> !ray_ready)
        else $error("ray port ready mid walk");

endmodule

bind voxel_grid_ray_walk_top vgrw_chk u_vgrw_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .ray_valid    (ray.valid),
    .ray_ready    (ray.ready),
    .vox_valid    (vox.valid),
    .vox_ready    (vox.ready),
    .cell_x       (vox.cell_x),
    .cell_y       (vox.cell_y),
    .cell_z       (vox.cell_z),
    .exit_distance(vox.exit_distance),
    .outside_start(vox.outside_start),
    .last         (vox.last)
);
